[src/hse_pkg.sv]
package hse_pkg;

  // Fixed widths of the stream fields and of the register port
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned TDATA_W    = 2 * FIELD_W;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index, taken from paddr[APB_ADDR_W-1:2]
  localparam logic [APB_ADDR_W-3:0] REG_KEY_SIGNED = '0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BLD_RD,
    ST_BLD_HOLD,
    ST_PICK,
    ST_DEC,
    ST_PUT,
    ST_EXT_RD,
    ST_EXT_SWAP,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_e;

endpackage

[src/hse_cmp.sv]
module hse_cmp #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0] a_key_i,
  input  logic [KEY_BITS-1:0] b_key_i,
  input  logic                key_signed_i,
  output logic                a_gt_o
);

  logic [KEY_BITS-1:0] flip;
  logic [KEY_BITS-1:0] a_rank;
  logic [KEY_BITS-1:0] b_rank;

  // Flip the sign bit so a two's complement order becomes an unsigned one
  assign flip   = {key_signed_i, {(KEY_BITS-1){1'b0}}};
  assign a_rank = a_key_i ^ flip;
  assign b_rank = b_key_i ^ flip;
  assign a_gt_o = a_rank > b_rank;

endmodule

[src/heap_sort_engine.sv]
// Channel  | Direction | Handshake                    | Contents
// s_axis   | in        | s_axis_tvalid / s_axis_tready | record: key, payload, last flag
// m_axis   | out       | m_axis_tvalid / m_axis_tready | sorted record, last flag, overflow
// apb      | in        | psel / penable, pready = 1    | key_signed register at index 0
//
// Loading accepts one record per cycle. The record with tlast starts a heapsort in place:
// each sift runs on the shared comparator. Output reads each record, then holds it on
// m_axis until it is taken before reading the next. s_axis_tready stays low from the last
// record's transfer to the final output.
// Reset clears the record count, overflow flag and key_signed; the store needs no clearing.
// A stall on m_axis holds the current record on the port.
module heap_sort_engine #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hse_pkg::TDATA_W-1:0]       s_axis_tdata,  // sort_key, payload
  input  logic                              s_axis_tlast,  // last_item
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hse_pkg::TDATA_W-1:0]       m_axis_tdata,  // out_key, out_payload
  output logic                              m_axis_tlast,  // out_last
  output logic                              m_axis_tuser,  // overflowed
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hse_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hse_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hse_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = KEY_BITS + PAYLOAD_BITS;

  hse_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               key_signed_q;
  logic               extract_q, extract_d;
  logic [IDX_W-1:0]   r_q, r_d;
  logic [IDX_W-1:0]   iter_q, iter_d;
  logic [IDX_W-1:0]   last_q, last_d;
  logic [IDX_W-1:0]   nlast_q, nlast_d;
  logic [IDX_W-1:0]   pick_idx_q, pick_idx_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [ENTRY_W-1:0] held_q, held_d;
  logic [ENTRY_W-1:0] pick_data_q, pick_data_d;

  logic [ENTRY_W-1:0] store_q [DEPTH];
  logic [ENTRY_W-1:0] rd_a_q, rd_b_q;
  logic               we, re_a, re_b;
  logic [IDX_W-1:0]   waddr, ra, rb;
  logic [ENTRY_W-1:0] wdata;

  logic [IDX_W-1:0]   node_sel, last_sel;
  logic [IDX_W:0]     child_l, child_r;
  logic               has_child, right_ok;
  logic [IDX_W-1:0]   rb_child;

  logic               in_xfer, full;
  logic [IDX_W-1:0]   nlast_in, r0;
  logic [IDX_W:0]     half;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic               a_gt;
  logic               cfg_wr;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
               && (paddr[hse_pkg::APB_ADDR_W-1:2] == hse_pkg::REG_KEY_SIGNED);

  always_comb begin
    prdata = '0;
    if (paddr[hse_pkg::APB_ADDR_W-1:2] == hse_pkg::REG_KEY_SIGNED) begin
      prdata[0] = key_signed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_signed_q <= 1'b0;
    end else if (cfg_wr) begin
      key_signed_q <= pwdata[0];
    end
  end

  // Children of the node being sifted, bounded by the heap's last slot
  always_comb begin
    node_sel = r_q;
    last_sel = last_q;
    case (state_q)
      hse_pkg::ST_DEC: begin
        node_sel = pick_idx_q;
      end
      hse_pkg::ST_EXT_SWAP: begin
        node_sel = '0;
        last_sel = iter_q - IDX_W'(1);
      end
      default: begin
        node_sel = r_q;
      end
    endcase
  end

  assign child_l   = {node_sel, 1'b1};
  assign child_r   = child_l + (IDX_W+1)'(1);
  assign has_child = child_l <= {1'b0, last_sel};
  assign right_ok  = child_r <= {1'b0, last_sel};
  assign rb_child  = right_ok ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];

  // Load bookkeeping
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign full     = count_q == CNT_W'(DEPTH);
  assign nlast_in = full ? IDX_W'(DEPTH - 1) : count_q[IDX_W-1:0];
  assign half     = ({1'b0, nlast_in} + (IDX_W+1)'(1)) >> 1;
  assign r0       = half[IDX_W-1:0] - IDX_W'(1);

  // Shared key comparator: children in PICK, chosen child against held record in DEC
  assign cmp_a = (state_q == hse_pkg::ST_DEC) ? pick_data_q[ENTRY_W-1:PAYLOAD_BITS]
                                              : rd_a_q[ENTRY_W-1:PAYLOAD_BITS];
  assign cmp_b = (state_q == hse_pkg::ST_DEC) ? held_q[ENTRY_W-1:PAYLOAD_BITS]
                                              : rd_b_q[ENTRY_W-1:PAYLOAD_BITS];

  hse_cmp #(
    .KEY_BITS(KEY_BITS)
  ) u_cmp (
    .a_key_i     (cmp_a),
    .b_key_i     (cmp_b),
    .key_signed_i(key_signed_q),
    .a_gt_o      (a_gt)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ovf_d         = ovf_q;
    extract_d     = extract_q;
    r_d           = r_q;
    iter_d        = iter_q;
    last_d        = last_q;
    nlast_d       = nlast_q;
    pick_idx_d    = pick_idx_q;
    out_idx_d     = out_idx_q;
    held_d        = held_q;
    pick_data_d   = pick_data_q;
    we            = 1'b0;
    waddr         = r_q;
    wdata         = held_q;
    re_a          = 1'b0;
    re_b          = 1'b0;
    ra            = child_l[IDX_W-1:0];
    rb            = rb_child;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    case (state_q)
      hse_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          if (!full) begin
            we      = 1'b1;
            waddr   = count_q[IDX_W-1:0];
            wdata   = {s_axis_tdata[KEY_BITS-1:0],
                       s_axis_tdata[hse_pkg::FIELD_W +: PAYLOAD_BITS]};
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            nlast_d   = nlast_in;
            last_d    = nlast_in;
            extract_d = 1'b0;
            out_idx_d = '0;
            if (nlast_in == '0) begin
              state_d = hse_pkg::ST_OUT_RD;
            end else begin
              iter_d  = r0;
              r_d     = r0;
              state_d = hse_pkg::ST_BLD_RD;
            end
          end
        end
      end
      hse_pkg::ST_BLD_RD: begin
        re_a    = 1'b1;
        ra      = iter_q;
        state_d = hse_pkg::ST_BLD_HOLD;
      end
      hse_pkg::ST_BLD_HOLD: begin
        // Every build root below n/2 has a left child
        held_d  = rd_a_q;
        re_a    = 1'b1;
        re_b    = 1'b1;
        state_d = hse_pkg::ST_PICK;
      end
      hse_pkg::ST_PICK: begin
        // Take the left child when it is the last slot or strictly larger
        if ((child_l == {1'b0, last_q}) || a_gt) begin
          pick_data_d = rd_a_q;
          pick_idx_d  = child_l[IDX_W-1:0];
        end else begin
          pick_data_d = rd_b_q;
          pick_idx_d  = child_r[IDX_W-1:0];
        end
        state_d = hse_pkg::ST_DEC;
      end
      hse_pkg::ST_DEC: begin
        state_d = hse_pkg::ST_PUT;
        if (a_gt) begin
          we    = 1'b1;
          waddr = r_q;
          wdata = pick_data_q;
          r_d   = pick_idx_q;
          if (has_child) begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            state_d = hse_pkg::ST_PICK;
          end
        end
      end
      hse_pkg::ST_PUT: begin
        // Drop the held record into the hole, then advance the outer loop
        we    = 1'b1;
        waddr = r_q;
        wdata = held_q;
        if (!extract_q) begin
          if (iter_q == '0) begin
            extract_d = 1'b1;
            iter_d    = nlast_q;
            state_d   = hse_pkg::ST_EXT_RD;
          end else begin
            iter_d  = iter_q - IDX_W'(1);
            r_d     = iter_q - IDX_W'(1);
            state_d = hse_pkg::ST_BLD_RD;
          end
        end else if (iter_q == IDX_W'(1)) begin
          out_idx_d = '0;
          state_d   = hse_pkg::ST_OUT_RD;
        end else begin
          iter_d  = iter_q - IDX_W'(1);
          state_d = hse_pkg::ST_EXT_RD;
        end
      end
      hse_pkg::ST_EXT_RD: begin
        re_a    = 1'b1;
        ra      = '0;
        re_b    = 1'b1;
        rb      = iter_q;
        state_d = hse_pkg::ST_EXT_SWAP;
      end
      hse_pkg::ST_EXT_SWAP: begin
        // Move the root to the end, sift the former end record from the root
        we     = 1'b1;
        waddr  = iter_q;
        wdata  = rd_a_q;
        held_d = rd_b_q;
        r_d    = '0;
        last_d = iter_q - IDX_W'(1);
        if (iter_q == IDX_W'(1)) begin
          state_d = hse_pkg::ST_PUT;
        end else begin
          re_a    = 1'b1;
          re_b    = 1'b1;
          state_d = hse_pkg::ST_PICK;
        end
      end
      hse_pkg::ST_OUT_RD: begin
        re_a    = 1'b1;
        ra      = out_idx_q;
        state_d = hse_pkg::ST_OUT_SHOW;
      end
      hse_pkg::ST_OUT_SHOW: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (out_idx_q == nlast_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = hse_pkg::ST_LOAD;
          end else begin
            out_idx_d = out_idx_q + IDX_W'(1);
            state_d   = hse_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = hse_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hse_pkg::ST_LOAD;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      extract_q  <= 1'b0;
      r_q        <= '0;
      iter_q     <= '0;
      last_q     <= '0;
      nlast_q    <= '0;
      pick_idx_q <= '0;
      out_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      extract_q  <= extract_d;
      r_q        <= r_d;
      iter_q     <= iter_d;
      last_q     <= last_d;
      nlast_q    <= nlast_d;
      pick_idx_q <= pick_idx_d;
      out_idx_q  <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q      <= held_d;
    pick_data_q <= pick_data_d;
  end

  // Record store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a) begin
      rd_a_q <= store_q[ra];
    end
    if (re_b) begin
      rd_b_q <= store_q[rb];
    end
  end

  assign m_axis_tdata = {hse_pkg::FIELD_W'(rd_a_q[PAYLOAD_BITS-1:0]),
                         hse_pkg::FIELD_W'(rd_a_q[ENTRY_W-1:PAYLOAD_BITS])};
  assign m_axis_tlast = out_idx_q == nlast_q;
  assign m_axis_tuser = ovf_q;

  // Input and output never open at the same time
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("record count beyond depth");

  a_end_of_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      (s_axis_tready && count_q == '0 && !ovf_q))
    else $error("set not closed after final record");

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_idx_q <= nlast_q))
    else $error("output index past last record");

endmodule
